/* sv/pfe_pkg.sv */
package pfe_pkg;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int NUM_VARS_DEF = 26;
   localparam int FRAC_BITS_DEF = 16;
   localparam int VW = 48;

   typedef enum logic [1:0] {KIND_LOAD = 2'd0, KIND_PUSH = 2'd1, KIND_OP = 2'd2,
      KIND_NOP = 2'd3} kind_type;
   typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2,
      OP_DIV = 2'd3} op_type;
   typedef enum logic [2:0] {ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2,
      ST_DIV0 = 3'd3, ST_SAT = 3'd4} status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [4:0]        var_index;
      logic signed [47:0] var_value;
      logic [1:0]        op_code;
      logic              last;
   } req_type;

   typedef struct packed {
      logic signed [47:0] value;
      logic [2:0]        status;
   } rsp_type;
endpackage

/* sv/pfe_if.sv */
interface pfe_req_if;
   logic                  valid;
   logic                  ready;
   pfe_pkg::req_type      payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pfe_rsp_if;
   logic                  valid;
   logic                  ready;
   pfe_pkg::rsp_type      payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/pfe_queue.sv */
module pfe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pfe_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pfe_pkg::req_type out_data
);
   import pfe_pkg::*;
   req_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
   end
endmodule

/* sv/pfe_alu.sv */
module pfe_alu #(
   parameter int FRAC_BITS = pfe_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         op,
   input  logic signed [47:0] lhs,
   input  logic signed [47:0] rhs,
   output logic               done,
   output logic signed [47:0] result,
   output logic               sat
);
   import pfe_pkg::*;
   localparam int STEPS = 48 + FRAC_BITS;
   localparam int CW = $clog2(STEPS + 1);
   localparam logic [47:0] POS = {1'b0, {47{1'b1}}};
   localparam logic [47:0] NEG = {1'b1, 47'd0};

   logic               busy_ff, busy_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [1:0]         op_ff;
   logic               neg_ff;
   logic [47:0]        ma_ff, mb_ff;
   logic [48:0]        rem_ff, rem_in;
   logic [48:0]        q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic [1:0]         ph_ff, ph_in;
   logic [63:0]        pa_ff, pb_ff, pc_ff, pd_ff;
   logic               done_ff, done_in;
   logic signed [47:0] res_ff, res_in;
   logic               sat_ff, sat_in;

   logic [47:0] mlhs, mrhs;
   logic [48:0] sum;
   logic [49:0] rsh;
   logic        bit_in;
   logic [95:0] prod;
   logic [95:0] shp;
   logic        mover;
   logic [48:0] mag;
   logic        over;

   assign mlhs = lhs[47] ? 48'(-lhs) : 48'(lhs);
   assign mrhs = rhs[47] ? 48'(-rhs) : 48'(rhs);
   assign done = done_ff;
   assign result = res_ff;
   assign sat = sat_ff;

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; rem_in = rem_ff; q_in = q_ff;
      ovf_in = ovf_ff; ph_in = ph_ff; done_in = 1'b0; res_in = res_ff;
      sat_in = sat_ff;
      sum = '0; rsh = '0; bit_in = 1'b0; prod = '0; shp = '0; mover = 1'b0;
      mag = '0; over = 1'b0;
      if (start) begin
         if (op == OP_ADD || op == OP_SUB) begin
            sum = (op == OP_ADD) ? 49'({lhs[47], lhs} + {rhs[47], rhs})
                                 : 49'({lhs[47], lhs} - {rhs[47], rhs});
            done_in = 1'b1;
            sat_in = sum[48] != sum[47];
            res_in = sat_in ? (sum[48] ? NEG : POS) : sum[47:0];
         end else begin
            busy_in = 1'b1;
            cnt_in = CW'(STEPS);
            rem_in = '0; q_in = '0; ovf_in = 1'b0; ph_in = '0;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) begin
               prod = {32'd0, pa_ff} + ({32'd0, pb_ff} << 24) + ({32'd0, pc_ff} << 24)
                    + ({32'd0, pd_ff} << 48);
               shp = prod >> FRAC_BITS;
               mover = shp[95:48] != '0;
               mag = {1'b0, shp[47:0]};
               over = mover || mag > (neg_ff ? {1'b0, NEG} : {1'b0, POS});
               res_in = over ? (neg_ff ? NEG : POS)
                             : (neg_ff ? 48'(-mag[47:0]) : mag[47:0]);
               sat_in = over;
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         end else begin
            bit_in = (cnt_ff > CW'(FRAC_BITS))
                   ? ma_ff[6'(cnt_ff - CW'(FRAC_BITS) - CW'(1))] : 1'b0;
            rsh = {rem_ff, bit_in};
            q_in = {q_ff[47:0], 1'b0};
            if (rsh >= {2'd0, mb_ff}) begin
               rsh = rsh - {2'd0, mb_ff};
               q_in[0] = 1'b1;
            end
            rem_in = rsh[48:0];
            if (q_in > {1'b0, NEG}) begin
               q_in = {1'b0, NEG} + 49'd1;
               ovf_in = 1'b1;
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               over = ovf_in || q_in > (neg_ff ? {1'b0, NEG} : {1'b0, POS});
               res_in = over ? (neg_ff ? NEG : POS)
                             : (neg_ff ? 48'(-q_in[47:0]) : q_in[47:0]);
               sat_in = over;
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= op;
         neg_ff <= lhs[47] != rhs[47];
         ma_ff <= mlhs;
         mb_ff <= mrhs;
      end
      if (busy_ff && ph_ff == 2'd0) begin
         pa_ff <= 64'(ma_ff[23:0]) * 64'(mb_ff[23:0]);
         pb_ff <= 64'(ma_ff[47:24]) * 64'(mb_ff[23:0]);
         pc_ff <= 64'(ma_ff[23:0]) * 64'(mb_ff[47:24]);
         pd_ff <= 64'(ma_ff[47:24]) * 64'(mb_ff[47:24]);
      end
      cnt_ff <= cnt_in; rem_ff <= rem_in; q_ff <= q_in; ovf_ff <= ovf_in;
      ph_ff <= ph_in; res_ff <= res_in; sat_ff <= sat_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

/* sv/pfe_exec.sv */
module pfe_exec #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
   parameter int NUM_VARS = pfe_pkg::NUM_VARS_DEF,
   parameter int FRAC_BITS = pfe_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pfe_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pfe_pkg::rsp_type out_data
);
   import pfe_pkg::*;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_ALU, S_WAIT, S_TOP, S_EMIT}
      state_type;

   state_type          st_ff, st_in;
   logic signed [47:0] vars_ff [NUM_VARS];
   logic signed [47:0] stk [STACK_DEPTH];
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [2:0]         err_ff, err_in;
   req_type            cur_ff, cur_in;
   logic signed [47:0] rd_ff;
   logic [SW-1:0]      ra;
   logic signed [47:0] rhs_ff, rhs_in;
   logic               we;
   logic [SW-1:0]      wa;
   logic signed [47:0] wd;
   logic               v_we;
   logic               alu_start, alu_done, alu_sat;
   logic signed [47:0] alu_res;
   rsp_type            out_ff, out_in;
   logic               ov_ff, ov_in;
   logic signed [47:0] pv;

   pfe_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock, .reset, .start(alu_start), .op(cur_ff.op_code), .lhs(rd_ff),
      .rhs(rhs_ff), .done(alu_done), .result(alu_res), .sat(alu_sat));

   assign out_valid = ov_ff;
   assign out_data = out_ff;
   assign pv = (32'(in_data.var_index) < NUM_VARS) ? vars_ff[in_data.var_index[4:0]] : '0;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; err_in = err_ff; cur_in = cur_ff;
      rhs_in = rhs_ff; we = 1'b0; wa = cnt_ff[SW-1:0]; wd = pv; v_we = 1'b0;
      alu_start = 1'b0; out_in = out_ff; ov_in = ov_ff && !out_ready;
      ra = SW'(cnt_ff - CW'(1)); in_ready = 1'b0;
      case (st_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cur_in = in_data;
               st_in = in_data.last ? S_TOP : S_IDLE;
               case (in_data.kind)
                  KIND_LOAD: v_we = 32'(in_data.var_index) < NUM_VARS;
                  KIND_PUSH: begin
                     if (32'(cnt_ff) >= STACK_DEPTH) begin
                        if (err_ff == ST_OK) err_in = ST_OVER;
                     end else begin
                        we = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  KIND_OP: begin
                     if (cnt_ff < CW'(2)) begin
                        if (err_ff == ST_OK) err_in = ST_UNDER;
                     end else begin
                        st_in = S_RD1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD1: begin
            rhs_in = rd_ff;
            ra = SW'(cnt_ff - CW'(2));
            st_in = S_RD2;
         end
         S_RD2: begin
            ra = SW'(cnt_ff - CW'(2));
            st_in = S_ALU;
         end
         S_ALU: begin
            cnt_in = cnt_ff - CW'(2);
            if (cur_ff.op_code == OP_DIV && rhs_ff == '0) begin
               if (err_ff == ST_OK) err_in = ST_DIV0;
               we = 1'b1; wa = SW'(cnt_ff - CW'(2)); wd = '0;
               cnt_in = cnt_ff - CW'(1);
               st_in = cur_ff.last ? S_TOP : S_IDLE;
            end else begin
               alu_start = 1'b1;
               st_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (alu_done) begin
               we = 1'b1; wa = cnt_ff[SW-1:0]; wd = alu_res;
               cnt_in = cnt_ff + CW'(1);
               if (alu_sat && err_ff == ST_OK) err_in = ST_SAT;
               st_in = cur_ff.last ? S_TOP : S_IDLE;
            end
         end
         S_TOP: st_in = S_EMIT;
         S_EMIT: begin
            if (!ov_ff) begin
               out_in.value = (cnt_ff == '0) ? '0 : rd_ff;
               out_in.status = (cnt_ff == '0 && err_ff == ST_OK) ? ST_UNDER : err_ff;
               ov_in = 1'b1;
               cnt_in = '0;
               err_in = ST_OK;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) stk[wa] <= wd;
      rd_ff <= stk[ra];
      if (v_we) vars_ff[in_data.var_index[4:0]] <= in_data.var_value;
      cur_ff <= cur_in;
      rhs_ff <= rhs_in;
      out_ff <= out_in;
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         err_ff <= ST_OK;
         ov_ff <= 1'b0;
         for (int i = 0; i < NUM_VARS; i++) vars_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
         ov_ff <= ov_in;
      end
   end
endmodule

/* sv/postfix_expression_evaluator.sv */
// Postfix evaluator over 48-bit signed fixed-point values. Tokens enter a
// four-beat queue; the back end takes one token at a time. Multiply forms
// four 24x24 partial products, a divide by zero skips the ALU and writes
// zero, and divide runs the one-bit-per-cycle restoring divider. A last
// token passes through the stack read and the result register; a result
// held by the receiver stalls only the next last token, and the input
// stalls once the queue is full behind it.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
   parameter int NUM_VARS = pfe_pkg::NUM_VARS_DEF,
   parameter int FRAC_BITS = pfe_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   pfe_req_if.sink   req,
   pfe_rsp_if.source rsp
);
   import pfe_pkg::*;
   logic    q_valid, q_ready;
   req_type q_data;

   pfe_queue u_queue (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_data(req.payload), .out_valid(q_valid), .out_ready(q_ready),
      .out_data(q_data));

   pfe_exec #(.STACK_DEPTH(STACK_DEPTH), .NUM_VARS(NUM_VARS),
      .FRAC_BITS(FRAC_BITS)) u_exec (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload));

   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.status <= ST_SAT) else $error("bad status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("rsp dropped");
endmodule
